// File: sv/icv_pkg.sv
`default_nettype none

package icv_pkg;

    localparam int SIZE_BITS_DEF = 24;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int CRC_W         = 32;

    localparam logic [CRC_W-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY     = 32'hEDB8_8320;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_CRC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_CAPACITY = 2'd2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_MISMATCH = 2'd2
    } t_status;

    typedef struct packed {
        logic             valid;
        t_status          status;
        logic [CRC_W-1:0] crc;
    } t_result;

    // reflected CRC-32, one byte, LSB first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0]       b);
        logic [CRC_W-1:0] c;
        c = crc ^ {24'h00_0000, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/icv_in_if.sv
`default_nettype none

interface icv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       first;

    modport source (output valid, output byte_value, output first, input ready);
    modport sink   (input valid, input byte_value, input first, output ready);
endinterface

`default_nettype wire

// File: sv/icv_out_if.sv
`default_nettype none

interface icv_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] computed_crc;

    modport source (output valid, output status, output computed_crc, input ready);
    modport sink   (input valid, input status, input computed_crc, output ready);
endinterface

`default_nettype wire

// File: sv/image_crc32_verifier.sv
// Firmware image CRC-32 checker.
// i_item (sink): one image byte per item plus a first flag. An item with first
//   set restarts the check; the size is tested there (zero or above capacity
//   gives a bad-size result with computed_crc zero).
// o_result (source): at most one item per check: status (ok, bad size,
//   mismatch) and the final inverted CRC-32 of the bytes taken in.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 image size,
//   1 expected CRC, 2 area capacity) at the clock edge; write only while idle.
// Path: an accepted item waits in the input register; the check processes it as it
//   leaves that register, and its result is held in the result register.
// Throughput: one item per cycle while o_result is not stalled; the byte-wide CRC
//   network is combinational between the input register and the result register.
// Reset (i_rst_n, synchronous): registers zero, CRC all ones, check idle
//   until a first item; both pipeline registers empty.
// Stall: while a result waits on o_result.ready the input register can still
//   hold one item; i_item.ready drops only when both are full and stalled.
`default_nettype none

module image_crc32_verifier
    import icv_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    icv_in_if.sink                     i_item,
    icv_out_if.source                  o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // config registers
    logic [SIZE_BITS-1:0] r_image_size;
    logic [CRC_W-1:0]     r_expected_crc;
    logic [SIZE_BITS-1:0] r_area_capacity;

    // input register
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_first;

    // result register
    logic             r_out_valid, n_out_valid;
    t_status          r_out_status;
    logic [CRC_W-1:0] r_out_crc;

    logic    out_free, s1_fire, in_accept;
    t_result res;

    assign out_free  = !r_out_valid || o_result.ready;
    assign s1_fire   = r_s1_valid && out_free;
    assign in_accept = i_item.valid && i_item.ready;

    assign i_item.ready          = !r_s1_valid || out_free;
    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_out_status;
    assign o_result.computed_crc = r_out_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size    <= '0;
            r_expected_crc  <= '0;
            r_area_capacity <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_SIZE:    r_image_size    <= i_cfg_data[SIZE_BITS-1:0];
                CFG_EXPECTED_CRC:  r_expected_crc  <= i_cfg_data[CRC_W-1:0];
                CFG_AREA_CAPACITY: r_area_capacity <= i_cfg_data[SIZE_BITS-1:0];
                default: ;  // unused index
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_byte  <= i_item.byte_value;
            r_s1_first <= i_item.first;
        end
    end

    icv_check #(
        .SIZE_BITS (SIZE_BITS)
    ) u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (s1_fire),
        .i_byte          (r_s1_byte),
        .i_first         (r_s1_first),
        .i_image_size    (r_image_size),
        .i_expected_crc  (r_expected_crc),
        .i_area_capacity (r_area_capacity),
        .o_res           (res)
    );

    // a free result slot takes the new result or empties
    assign n_out_valid = out_free ? (s1_fire && res.valid) : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && res.valid) begin
            r_out_status <= res.status;
            r_out_crc    <= res.crc;
        end
    end

endmodule

`default_nettype wire

// File: sv/icv_check.sv
`default_nettype none

module icv_check
    import icv_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire logic [7:0]           i_byte,
    input  wire logic                 i_first,
    input  wire logic [SIZE_BITS-1:0] i_image_size,
    input  wire logic [CRC_W-1:0]     i_expected_crc,
    input  wire logic [SIZE_BITS-1:0] i_area_capacity,
    output t_result                   o_res
);

    logic [CRC_W-1:0]     r_crc, n_crc;
    logic [SIZE_BITS-1:0] r_count, n_count;
    logic                 r_finished, n_finished;

    logic [CRC_W-1:0]     crc_base, crc_upd, crc_final;
    logic [SIZE_BITS-1:0] count_base, count_upd;
    logic                 bad_size;

    assign crc_base   = i_first ? CRC_ALL_ONES : r_crc;
    assign count_base = i_first ? '0 : r_count;
    assign crc_upd    = crc_byte(crc_base, i_byte);
    assign count_upd  = count_base + SIZE_BITS'(1);
    assign crc_final  = crc_upd ^ CRC_ALL_ONES;
    assign bad_size   = (i_image_size == '0) || (i_image_size > i_area_capacity);

    always_comb begin
        n_crc        = r_crc;
        n_count      = r_count;
        n_finished   = r_finished;
        o_res.valid  = 1'b0;
        o_res.status = ST_OK;
        o_res.crc    = '0;
        if (i_fire) begin
            if (i_first && bad_size) begin
                n_crc        = CRC_ALL_ONES;
                n_count      = '0;
                n_finished   = 1'b1;
                o_res.valid  = 1'b1;
                o_res.status = ST_BAD_SIZE;
            end else if (i_first || !r_finished) begin
                n_crc      = crc_upd;
                n_count    = count_upd;
                n_finished = 1'b0;
                if (count_upd >= i_image_size) begin
                    n_finished   = 1'b1;
                    o_res.valid  = 1'b1;
                    o_res.status = (crc_final == i_expected_crc) ? ST_OK : ST_MISMATCH;
                    o_res.crc    = crc_final;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= CRC_ALL_ONES;
            r_count    <= '0;
            r_finished <= 1'b1;
        end else begin
            r_crc      <= n_crc;
            r_count    <= n_count;
            r_finished <= n_finished;
        end
    end

`ifndef SYNTHESIS
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> r_finished)
        else $error("check not idle after reset");
    a_result_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.valid |=> r_finished)
        else $error("result given but check still running");
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !i_first && r_finished |-> !o_res.valid && (n_crc == r_crc))
        else $error("idle check reacted to a byte");
`endif

endmodule

`default_nettype wire
